[src/kmcd_pkg.sv]
// Shared types, constants and helper functions for the key matrix change detector.
package kmcd_pkg;

  localparam int ROW_BYTE_W  = 8;
  localparam int REG_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int COL_FIELD_W = 3;
  localparam int CODE_W      = 7;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;

  localparam logic [REG_W-1:0] ROW_COUNT_RST    = 4'd8;
  localparam logic [REG_W-1:0] COLUMN_COUNT_RST = 4'd8;

  typedef struct packed {
    logic              key_down;
    logic [CODE_W-1:0] key_code;
  } kmcd_result_t;

  function automatic logic [2:0] top_bit(input logic [ROW_BYTE_W-1:0] v);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 1; i < ROW_BYTE_W; i++) begin
      if (v[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

endpackage

[src/kmcd_scan_core.sv]
// Column state store, change compare, event latch and key code encoder.
module kmcd_scan_core import kmcd_pkg::*; #(
  parameter int MAX_COLUMNS = 8,
  parameter int MAX_ROWS    = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [ROW_BYTE_W-1:0] row_bits,
  input  logic [REG_W-1:0]      row_count,
  input  logic [REG_W-1:0]      column_count,
  output logic                  emit,
  output kmcd_result_t          result
);

  localparam int COL_IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  logic [MAX_ROWS-1:0]  rows_r [MAX_COLUMNS];
  logic [COL_IDX_W-1:0] scan_col_r;
  logic                 pend_r;
  logic [COL_IDX_W-1:0] ev_col_r;
  logic [MAX_ROWS-1:0]  ev_changed_r;
  logic                 ev_down_r;

  logic [REG_W-1:0]     rows_used;
  logic [REG_W-1:0]     cols_used;
  logic [REG_W-1:0]     last_col;
  logic                 at_end;
  logic [MAX_ROWS-1:0]  mask;
  logic [MAX_ROWS-1:0]  key;
  logic [MAX_ROWS-1:0]  changed;
  logic                 take;
  logic                 pend_nxt;
  logic [COL_IDX_W-1:0] ev_col_nxt;
  logic [MAX_ROWS-1:0]  ev_changed_nxt;
  logic                 ev_down_nxt;

  always_comb begin
    rows_used = (row_count > REG_W'(MAX_ROWS)) ? REG_W'(MAX_ROWS) : row_count;
    if (column_count == '0) begin
      cols_used = REG_W'(1);
    end else if (column_count > REG_W'(MAX_COLUMNS)) begin
      cols_used = REG_W'(MAX_COLUMNS);
    end else begin
      cols_used = column_count;
    end
    last_col = cols_used - REG_W'(1);
    at_end   = REG_W'(scan_col_r) >= last_col;
    for (int i = 0; i < MAX_ROWS; i++) begin
      mask[i] = REG_W'(i) < rows_used;
    end
    key     = row_bits[MAX_ROWS-1:0] & mask;
    changed = rows_r[scan_col_r] ^ key;
    take    = (changed != '0) &&
              (!pend_r || (changed == ev_changed_r && ev_col_r == '0 && at_end));
    pend_nxt       = pend_r | take;
    ev_col_nxt     = take ? scan_col_r : ev_col_r;
    ev_changed_nxt = take ? changed : ev_changed_r;
    ev_down_nxt    = take ? |(key & changed) : ev_down_r;
    emit            = at_end && pend_nxt;
    result.key_down = ev_down_nxt;
    result.key_code = CODE_W'({COL_FIELD_W'(ev_col_nxt),
                               top_bit(ROW_BYTE_W'(ev_changed_nxt))}) + CODE_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_COLUMNS; i++) begin
        rows_r[i] <= '0;
      end
      scan_col_r   <= '0;
      pend_r       <= 1'b0;
      ev_col_r     <= '0;
      ev_changed_r <= '0;
      ev_down_r    <= 1'b0;
    end else if (step) begin
      if (changed != '0) begin
        rows_r[scan_col_r] <= key;
      end
      if (at_end) begin
        scan_col_r   <= '0;
        pend_r       <= 1'b0;
        ev_col_r     <= '0;
        ev_changed_r <= '0;
        ev_down_r    <= 1'b0;
      end else begin
        scan_col_r   <= scan_col_r + COL_IDX_W'(1);
        pend_r       <= pend_nxt;
        ev_col_r     <= ev_col_nxt;
        ev_changed_r <= ev_changed_nxt;
        ev_down_r    <= ev_down_nxt;
      end
    end
  end

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    scan_col_r <= COL_IDX_W'(MAX_COLUMNS - 1))
    else $error("scan column beyond the last stored column");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && at_end |=> scan_col_r == '0 && !pend_r)
    else $error("scan end did not clear the event and the column counter");

  a_pend_has_change: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ev_changed_r != '0)
    else $error("pending event without changed bits");

  a_emit_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    step && emit |-> at_end && (pend_r || changed != '0))
    else $error("result emitted away from the scan end or without an event");

endmodule

[src/kmcd_out_reg.sv]
// Result register that holds one word until the downstream side takes it.
module kmcd_out_reg import kmcd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  kmcd_result_t load_data,
  output logic         free,
  input  logic         out_tready,
  output logic         out_valid,
  output kmcd_result_t out_data
);

  logic         valid_r;
  kmcd_result_t data_r;

  assign free      = !valid_r || out_tready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

[src/key_matrix_change_detector.sv]
// Key matrix change detector: one row word per scanned column in, at most one
// key event per scan out. A column word is taken every clock cycle while the
// result side keeps up; the word is held in the input register, is
// compared with the stored column state in a single pass, and any key event
// is loaded into the output register when the word of the last column
// steps on from the input register. Only a pending result that is not
// taken stalls the input. The column state is cleared by reset, so no start-up
// pass is needed, and configuration writes are taken in any cycle.
module key_matrix_change_detector import kmcd_pkg::*; #(
  parameter int MAX_COLUMNS = 8,
  parameter int MAX_ROWS    = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,    // [7:0] row_bits
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,   // [0] key_down, [7:1] key_code
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  logic [REG_W-1:0]      row_count_r;
  logic [REG_W-1:0]      column_count_r;
  logic                  s1_valid_r;
  logic [ROW_BYTE_W-1:0] s1_row_r;
  logic                  step;
  logic                  emit;
  logic                  out_free;
  kmcd_result_t          result;
  kmcd_result_t          out_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= ROW_COUNT_RST;
      column_count_r <= COLUMN_COUNT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROW_COUNT:    row_count_r    <= cfg_data;
        REG_COLUMN_COUNT: column_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign step      = s1_valid_r && (!emit || out_free);
  assign in_tready = !s1_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_row_r <= in_tdata;
    end
  end

  kmcd_scan_core #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .row_bits    (s1_row_r),
    .row_count   (row_count_r),
    .column_count(column_count_r),
    .emit        (emit),
    .result      (result)
  );

  kmcd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && emit),
    .load_data (result),
    .free      (out_free),
    .out_tready(out_tready),
    .out_valid (out_tvalid),
    .out_data  (out_word)
  );

  assign out_tdata = {out_word.key_code, out_word.key_down};

endmodule
